FILE: src/data_header_stream_parser_assert.svh
// Assertion macros used by the checker file.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef DATA_HEADER_STREAM_PARSER_ASSERT_SVH
`define DATA_HEADER_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication.
`define DHSP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dhsp check failed");

// Next-cycle implication.
`define DHSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dhsp check failed");

`endif

FILE: src/dhsp_pkg.sv
// ----------------------------------------------------------------------------
// dhsp_pkg
// Types and constants for the data header stream parser.
// ----------------------------------------------------------------------------
package dhsp_pkg;

  localparam int LENGTH_BITS = 16;

  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    PH_HUNT      = 4'd0,
    PH_I         = 4'd1,
    PH_P         = 4'd2,
    PH_D         = 4'd3,
    PH_COMMA1    = 4'd4,
    PH_CHAN      = 4'd5,
    PH_COMMA2    = 4'd6,
    PH_LEN_FIRST = 4'd7,
    PH_LEN_MORE  = 4'd8,
    PH_PAYLOAD   = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_HEADER = 2'd1,
    EV_DATA   = 2'd2,
    EV_ERROR  = 2'd3
  } event_t;

  typedef struct packed {
    logic       func;     // 1 = byte-wait timeout
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    event_t                 event_res;
    logic [3:0]             chan_digit;
    logic [LENGTH_BITS-1:0] payload_length;
    logic [7:0]             payload_byte;
    logic                   last_payload;
  } result_t;

endpackage

FILE: src/data_header_stream_parser.sv
// ----------------------------------------------------------------------------
// data_header_stream_parser
// Finds "+IPD,<c>,<n>:" headers in a byte stream and passes n payload bytes.
// ----------------------------------------------------------------------------
// An accepted item passes the input register, then the result register;
// the parser state is updated with the result register.
// Throughput: one item per cycle unless result_stall holds the pipeline, one result per item.
// Reset (rst, synchronous): parser hunts for '+', channel and length cleared,
// both pipeline registers empty.
module data_header_stream_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  dhsp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output dhsp_pkg::result_t result
);

  localparam int LB = dhsp_pkg::LENGTH_BITS;

  // input register
  logic            s1_valid;
  dhsp_pkg::item_t s1;

  // parser state
  dhsp_pkg::phase_t phase, phase_next;
  logic [3:0]       channel_reg, channel_reg_next;
  logic [LB-1:0]    length_count, length_count_next;

  dhsp_pkg::result_t res_next;

  logic out_adv, s1_adv;

  assign out_adv    = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && out_adv;
  assign item_stall = s1_valid && !out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
    if (!item_stall && item_valid) begin
      s1 <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      phase        <= dhsp_pkg::PH_HUNT;
      channel_reg  <= '0;
      length_count <= '0;
    end else begin
      if (out_adv) begin
        result_valid <= s1_valid;
      end
      if (s1_adv) begin
        phase        <= phase_next;
        channel_reg  <= channel_reg_next;
        length_count <= length_count_next;
      end
    end
    if (s1_adv) begin
      result <= res_next;
    end
  end

  logic          timeout, digit;
  logic [3:0]    dv;
  logic [LB+3:0] len_ext;   // length * 10 + digit, with headroom
  logic          len_over;
  logic [7:0]    want;
  logic          fixed_char;
  dhsp_pkg::phase_t fixed_next;
  dhsp_pkg::event_t ev;
  logic [7:0]    pbyte;
  logic          last;
  logic [LB-1:0] len_dec;

  always_comb begin
    timeout  = s1.func;
    digit    = (s1.rx_byte >= dhsp_pkg::CH_ZERO) && (s1.rx_byte <= dhsp_pkg::CH_NINE);
    dv       = 4'(s1.rx_byte - dhsp_pkg::CH_ZERO);
    len_ext  = ({4'd0, length_count} << 3) + ({4'd0, length_count} << 1)
               + {{LB{1'b0}}, dv};
    len_over = |len_ext[LB+3:LB];
    len_dec  = (length_count != '0) ? length_count - LB'(1) : length_count;

    want       = dhsp_pkg::CH_COMMA;
    fixed_char = 1'b0;
    fixed_next = dhsp_pkg::PH_HUNT;
    case (phase)
      dhsp_pkg::PH_I:      begin want = dhsp_pkg::CH_I;     fixed_char = 1'b1;
                                 fixed_next = dhsp_pkg::PH_P;         end
      dhsp_pkg::PH_P:      begin want = dhsp_pkg::CH_P;     fixed_char = 1'b1;
                                 fixed_next = dhsp_pkg::PH_D;         end
      dhsp_pkg::PH_D:      begin want = dhsp_pkg::CH_D;     fixed_char = 1'b1;
                                 fixed_next = dhsp_pkg::PH_COMMA1;    end
      dhsp_pkg::PH_COMMA1: begin want = dhsp_pkg::CH_COMMA; fixed_char = 1'b1;
                                 fixed_next = dhsp_pkg::PH_CHAN;      end
      dhsp_pkg::PH_COMMA2: begin want = dhsp_pkg::CH_COMMA; fixed_char = 1'b1;
                                 fixed_next = dhsp_pkg::PH_LEN_FIRST; end
      default: ;
    endcase

    phase_next        = phase;
    channel_reg_next  = channel_reg;
    length_count_next = length_count;
    ev                = dhsp_pkg::EV_NONE;
    pbyte             = '0;
    last              = 1'b0;

    if (fixed_char) begin
      if (timeout || s1.rx_byte != want) begin
        ev = dhsp_pkg::EV_ERROR;
      end else begin
        phase_next = fixed_next;
      end
    end else begin
      case (phase)
        dhsp_pkg::PH_CHAN: begin
          if (timeout || !digit) begin
            ev = dhsp_pkg::EV_ERROR;
          end else begin
            channel_reg_next = dv;
            phase_next       = dhsp_pkg::PH_COMMA2;
          end
        end
        dhsp_pkg::PH_LEN_FIRST, dhsp_pkg::PH_LEN_MORE: begin
          if (!timeout && digit) begin
            if (len_over) begin
              ev = dhsp_pkg::EV_ERROR;
            end else begin
              length_count_next = len_ext[LB-1:0];
              phase_next        = dhsp_pkg::PH_LEN_MORE;
            end
          end else if (phase == dhsp_pkg::PH_LEN_MORE && !timeout &&
                       s1.rx_byte == dhsp_pkg::CH_COLON) begin
            ev         = dhsp_pkg::EV_HEADER;
            phase_next = (length_count == '0) ? dhsp_pkg::PH_HUNT : dhsp_pkg::PH_PAYLOAD;
          end else begin
            ev = dhsp_pkg::EV_ERROR;
          end
        end
        dhsp_pkg::PH_PAYLOAD: begin
          // timeouts are ignored here
          if (!timeout) begin
            ev                = dhsp_pkg::EV_DATA;
            pbyte             = s1.rx_byte;
            length_count_next = len_dec;
            if (len_dec == '0) begin
              last       = 1'b1;
              phase_next = dhsp_pkg::PH_HUNT;
            end
          end
        end
        default: begin
          // hunting, and any stray phase code
          phase_next = dhsp_pkg::PH_HUNT;
          if (!timeout && s1.rx_byte == dhsp_pkg::CH_PLUS) begin
            channel_reg_next  = '0;
            length_count_next = '0;
            phase_next        = dhsp_pkg::PH_I;
          end
        end
      endcase
    end

    if (ev == dhsp_pkg::EV_ERROR) begin
      phase_next        = dhsp_pkg::PH_HUNT;
      channel_reg_next  = '0;
      length_count_next = '0;
    end

    res_next.event_res      = ev;
    res_next.chan_digit     = channel_reg_next;
    res_next.payload_length = length_count_next;
    res_next.payload_byte   = pbyte;
    res_next.last_payload   = last;
  end

endmodule

FILE: src/dhsp_checker.sv
// ----------------------------------------------------------------------------
// dhsp_checker
// Port-level checks on the data header stream parser, bound to the parser module.
// ----------------------------------------------------------------------------
`include "data_header_stream_parser_assert.svh"

module dhsp_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input dhsp_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input dhsp_pkg::result_t result
);

  logic res_hold, item_hold;
  logic last_seen, last_ok;
  logic other_seen, other_ok;
  logic err_seen, err_ok;

  assign res_hold   = result_valid && result_stall;
  assign item_hold  = item_valid && item_stall;
  assign last_seen  = result_valid && result.last_payload;
  assign last_ok    = result.event_res == dhsp_pkg::EV_DATA && result.payload_length == '0;
  assign other_seen = result_valid && result.event_res != dhsp_pkg::EV_DATA;
  assign other_ok   = result.payload_byte == '0 && !result.last_payload;
  assign err_seen   = result_valid && result.event_res == dhsp_pkg::EV_ERROR;
  assign err_ok     = result.chan_digit == '0 && result.payload_length == '0;

  // a stalled result transaction keeps its payload
  `DHSP_ASSERT_NEXT(a_result_hold, clk, rst, res_hold, result_valid && $stable(result))

  // a stalled input transaction keeps its payload
  `DHSP_ASSERT_NEXT(a_item_hold, clk, rst, item_hold, item_valid && $stable(item))

  // the last payload byte leaves nothing still to come
  `DHSP_ASSERT_NOW(a_last_empty, clk, rst, last_seen, last_ok)

  // payload byte is zero and last flag clear unless a data result
  `DHSP_ASSERT_NOW(a_byte_zero, clk, rst, other_seen, other_ok)

  // a header error clears channel and length
  `DHSP_ASSERT_NOW(a_error_clear, clk, rst, err_seen, err_ok)

endmodule

bind data_header_stream_parser dhsp_checker u_dhsp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
